FILE: design/utf8_to_code_point_decoder_defines.svh
// assertion macros for the utf8 decoder
// used by the top level only, which supplies clk_i and rst_ni in scope
`ifndef UTF8_TO_CODE_POINT_DECODER_DEFINES_SVH
`define UTF8_TO_CODE_POINT_DECODER_DEFINES_SVH

// property checked at every clock edge outside reset
`define UTD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("utf8 decoder check failed");

// antecedent implies consequent in the same cycle
`define UTD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utf8 decoder check failed");

`endif

FILE: design/utd_pkg.sv
// shared types and constants of the utf8 decoder
// no dependencies
package utd_pkg;

  localparam int CountW   = 16;  // width of the internal character counter
  localparam int CapW     = 16;
  localparam int ResW     = 3;
  localparam int OutCntW  = 16;
  localparam int CpW      = 21;
  localparam int SumW     = ((CountW > CapW) ? CountW : CapW) + 1;
  localparam int CfgAddrW = 1;
  localparam int CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] CfgCapacity = 1'd0;
  localparam logic [CfgAddrW-1:0] CfgReserve  = 1'd1;

  localparam logic [CapW-1:0] CapacityReset = 16'hFFFF;
  localparam logic [ResW-1:0] ReserveReset  = 3'd2;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StNoRoom = 2'd1,
    StTrunc  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic               char_valid;
    logic [CpW-1:0]     code_point;
    logic               end_of_run;
    logic [OutCntW-1:0] char_count;
    logic [1:0]         status;
  } res_item_t;

endpackage

FILE: design/utf8_to_code_point_decoder.sv
// top level of the utf8 decoder: configuration registers and stage wiring
// depends on utd_pkg, utd_in_reg, utd_core, utd_out_reg and the defines header
//
// Usage:
//   Bytes enter on in_valid_i / in_stall_o with in_byte_i and is_last_i;
//   results leave on out_valid_o / out_stall_i. An item moves at a clock
//   edge where valid is high and stall is low.
//   A result is given when a character completes or on the last byte of a
//   run; other bytes give none. The last byte's result carries end_of_run,
//   the character count (zero on error) and the status.
//   A byte accepted into the input register is decoded and its result is then held in the result register.
//   Throughput: one byte per cycle while the receiver does not stall, set by
//   the single decode stage between the input register and the result register.
//   When the receiver stalls, the result register holds its item, the input
//   register fills behind it and in_stall_o rises; bytes that give no
//   result still pass through.
//   Reset clears the decode state and loads capacity 65535 and reserve 2.
//   Configuration is written through cfg_we_i, cfg_addr_i and cfg_wdata_i
//   (index 0 capacity, index 1 reserve); the user writes it only while the block is idle, not enforced by the block.
`include "utf8_to_code_point_decoder_defines.svh"

module utf8_to_code_point_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [utd_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [utd_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     in_byte_i,
  input  logic                           is_last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           char_valid_o,
  output logic [utd_pkg::CpW-1:0]        code_point_o,
  output logic                           end_of_run_o,
  output logic [utd_pkg::OutCntW-1:0]    char_count_o,
  output logic [1:0]                     status_o
);

  logic [utd_pkg::CapW-1:0] capacity_q;
  logic [utd_pkg::ResW-1:0] reserve_q;

  utd_pkg::in_item_t  in_item;
  utd_pkg::in_item_t  stage_item;
  logic               stage_valid;
  logic               advance;
  logic               res_valid;
  logic               out_ready;
  utd_pkg::res_item_t res;
  utd_pkg::res_item_t out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= utd_pkg::CapacityReset;
      reserve_q  <= utd_pkg::ReserveReset;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == utd_pkg::CfgCapacity) begin
        capacity_q <= cfg_wdata_i[utd_pkg::CapW-1:0];
      end
      if (cfg_addr_i == utd_pkg::CfgReserve) begin
        reserve_q <= cfg_wdata_i[utd_pkg::ResW-1:0];
      end
    end
  end

  assign in_item.in_byte = in_byte_i;
  assign in_item.is_last = is_last_i;

  utd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (stage_valid),
    .item_o       (stage_item)
  );

  utd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (stage_valid),
    .item_i       (stage_item),
    .out_ready_i  (out_ready),
    .capacity_i   (capacity_q),
    .reserve_i    (reserve_q),
    .advance_o    (advance),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  utd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign char_valid_o = out_res.char_valid;
  assign code_point_o = out_res.code_point;
  assign end_of_run_o = out_res.end_of_run;
  assign char_count_o = out_res.char_count;
  assign status_o     = out_res.status;

  // a result exists only for a character or the end of a run
  `UTD_ASSERT_IMPL(a_res_reason, out_valid_o, char_valid_o || end_of_run_o)
  // count and status only travel on the end of a run
  `UTD_ASSERT_IMPL(a_mid_run_clean, out_valid_o && !end_of_run_o,
                   (status_o == utd_pkg::StOk) && (char_count_o == '0))
  // a failed run reports no characters
  `UTD_ASSERT_IMPL(a_err_zero_count, out_valid_o && (status_o != utd_pkg::StOk),
                   char_count_o == '0)
  // a stage item that produces a result cannot move while the output is full
  `UTD_ASSERT(a_no_overwrite, !(advance && res_valid && !out_ready))

endmodule

FILE: design/utd_in_reg.sv
// input register of the utf8 decoder: holds one accepted byte
// depends on utd_pkg
module utd_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  utd_pkg::in_item_t in_item_i,
  input  logic              advance_i,
  output logic              item_valid_o,
  output utd_pkg::in_item_t item_o
);

  logic              valid_q, valid_d;
  utd_pkg::in_item_t item_q;
  logic              take;

  // stage frees up when its item moves on
  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;
  assign valid_d    = take || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: design/utd_core.sv
// decode state and one-step decode logic of the utf8 decoder
// depends on utd_pkg
module utd_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       item_valid_i,
  input  utd_pkg::in_item_t          item_i,
  input  logic                       out_ready_i,
  input  logic [utd_pkg::CapW-1:0]   capacity_i,
  input  logic [utd_pkg::ResW-1:0]   reserve_i,
  output logic                       advance_o,
  output logic                       res_valid_o,
  output utd_pkg::res_item_t         res_o
);

  logic [utd_pkg::CpW-1:0]    part_q, part_d;
  logic [1:0]                 pend_q, pend_d;
  logic [utd_pkg::CountW-1:0] cnt_q, cnt_d;
  utd_pkg::status_e           err_q, err_d;

  logic                       done;
  logic [utd_pkg::CpW-1:0]    cp;
  logic [utd_pkg::SumW-1:0]   room_sum;
  logic                       no_room;
  logic [7:0]                 b;
  logic                       last;

  assign b        = item_i.in_byte;
  assign last     = item_i.is_last;
  assign room_sum = utd_pkg::SumW'(cnt_q) + utd_pkg::SumW'(reserve_i);
  assign no_room  = room_sum >= utd_pkg::SumW'(capacity_i);

  always_comb begin
    part_d = part_q;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    err_d  = err_q;
    done   = 1'b0;
    cp     = '0;
    if (err_q == utd_pkg::StOk) begin
      if (pend_q != 2'd0) begin
        // continuation bytes are not checked, low six bits are shifted in
        part_d = {part_q[utd_pkg::CpW-7:0], b[5:0]};
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          done = 1'b1;
          cp   = part_d;
        end
      end else if (b < 8'hF8) begin
        priority if (no_room) begin
          err_d = utd_pkg::StNoRoom;
        end else if (b < 8'h80) begin
          done = 1'b1;
          cp   = utd_pkg::CpW'(b & 8'h7F);
        end else if (b < 8'hE0) begin
          part_d = utd_pkg::CpW'(b & 8'h1F);
          pend_d = 2'd1;
        end else if (b < 8'hF0) begin
          part_d = utd_pkg::CpW'(b & 8'h0F);
          pend_d = 2'd2;
        end else begin
          part_d = utd_pkg::CpW'(b & 8'h07);
          pend_d = 2'd3;
        end
      end
      // counter saturates at all ones
      if (done && (cnt_q != '1)) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (last && (err_d == utd_pkg::StOk) && (pend_d != 2'd0)) begin
        err_d = utd_pkg::StTrunc;
      end
    end
  end

  assign res_valid_o = done || last;
  // items without a result never wait on the output side
  assign advance_o   = item_valid_i && (!res_valid_o || out_ready_i);

  always_comb begin
    res_o.char_valid = done;
    res_o.code_point = cp;
    res_o.end_of_run = last;
    res_o.char_count = (last && (err_d == utd_pkg::StOk)) ?
                       utd_pkg::OutCntW'(cnt_d) : '0;
    res_o.status     = last ? err_d : utd_pkg::StOk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      pend_q <= 2'd0;
      cnt_q  <= '0;
      err_q  <= utd_pkg::StOk;
    end else if (advance_o) begin
      if (last) begin
        // end of run returns to the reset state
        part_q <= '0;
        pend_q <= 2'd0;
        cnt_q  <= '0;
        err_q  <= utd_pkg::StOk;
      end else begin
        part_q <= part_d;
        pend_q <= pend_d;
        cnt_q  <= cnt_d;
        err_q  <= err_d;
      end
    end
  end

endmodule

FILE: design/utd_out_reg.sv
// result register of the utf8 decoder
// depends on utd_pkg
module utd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  utd_pkg::res_item_t res_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output utd_pkg::res_item_t res_o
);

  logic               valid_q, valid_d;
  utd_pkg::res_item_t res_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
